/* rtl/pus_pkg.sv */
package pus_pkg;

    // particle kinds
    localparam logic [2:0] KIND_STATIC   = 3'd0;
    localparam logic [2:0] KIND_FIRE     = 3'd1;
    localparam logic [2:0] KIND_EXPLODE  = 3'd2;
    localparam logic [2:0] KIND_EXPLODE2 = 3'd3;
    localparam logic [2:0] KIND_BLOB     = 3'd4;
    localparam logic [2:0] KIND_BLOB2    = 3'd5;
    localparam logic [2:0] KIND_GRAV     = 3'd6;
    localparam logic [2:0] KIND_SLOWGRAV = 3'd7;

    // configuration register indexes
    localparam logic [1:0] CFG_CURRENT_TIME = 2'd0;
    localparam logic [1:0] CFG_FRAME_TIME   = 2'd1;
    localparam logic [1:0] CFG_GRAVITY      = 2'd2;

    localparam logic [11:0] GRAVITY_RESET = 12'd800;

    // how gravity is applied to vertical velocity
    localparam logic [1:0] GMODE_NONE = 2'd0;
    localparam logic [1:0] GMODE_ADD  = 2'd1;
    localparam logic [1:0] GMODE_SUB  = 2'd2;

    // reciprocal of five in Q0.16, rounded down
    localparam logic [13:0] RECIP5 = 14'd13107;
    // largest gravity step for full frame time and gravity
    localparam logic [15:0] G_MAX = 16'd52415;

    localparam logic signed [28:0] SAT_MAX = 29'sd8388607;
    localparam logic signed [28:0] SAT_MIN = -29'sd8388608;

    typedef struct packed {
        logic [2:0]       kind;
        logic [15:0]      ramp;
        logic [7:0]       color;
        logic [31:0]      expiry;
        logic [2:0][23:0] pos;
        logic [2:0][23:0] vel;
    } t_in;

    typedef struct packed {
        logic [2:0]       kind;
        logic             expired;
        logic [15:0]      ramp;
        logic [15:0]      ramp_new;
        logic [7:0]       color;
        logic [31:0]      expiry;
        logic [2:0][23:0] pos;
        logic [2:0][23:0] vel;
        logic [2:0][39:0] prod;
        logic [27:0]      fg;
    } t_s1;

    typedef struct packed {
        logic             alive;
        logic [15:0]      ramp;
        logic [7:0]       color;
        logic [31:0]      expiry;
        logic [2:0][23:0] pos;
        logic [1:0][23:0] vel_xy;
        logic [27:0]      vel_z_part;
        logic [1:0]       gmode;
        logic [17:0]      gy;
        logic [15:0]      gq;
    } t_s2;

    typedef struct packed {
        logic             alive;
        logic [15:0]      ramp;
        logic [7:0]       color;
        logic [31:0]      expiry;
        logic [2:0][23:0] pos;
        logic [2:0][23:0] vel;
    } t_out;

    function automatic logic [23:0] sat24(input logic signed [28:0] v);
        logic [23:0] res;
        if (v > SAT_MAX) begin
            res = 24'h7FFFFF;
        end else if (v < SAT_MIN) begin
            res = 24'h800000;
        end else begin
            res = v[23:0];
        end
        return res;
    endfunction

    function automatic logic [7:0] fire_colour(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0: c = 8'h6D;
            3'd1: c = 8'h6B;
            3'd2: c = 8'h06;
            3'd3: c = 8'h05;
            3'd4: c = 8'h04;
            default: c = 8'h03;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] explode_colour(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0: c = 8'h6F;
            3'd1: c = 8'h6D;
            3'd2: c = 8'h6B;
            3'd3: c = 8'h69;
            3'd4: c = 8'h67;
            3'd5: c = 8'h65;
            3'd6: c = 8'h63;
            default: c = 8'h61;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] explode2_colour(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0: c = 8'h6F;
            3'd1: c = 8'h6E;
            3'd2: c = 8'h6D;
            3'd3: c = 8'h6C;
            3'd4: c = 8'h6B;
            3'd5: c = 8'h6A;
            3'd6: c = 8'h68;
            default: c = 8'h66;
        endcase
        return c;
    endfunction

endpackage

/* rtl/pus_mul_stage.sv */
module pus_mul_stage
    import pus_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_data,
    input  logic [30:0] i_current_time,
    input  logic [15:0] i_frame_time,
    input  logic [11:0] i_gravity,
    output logic        o_valid,
    input  logic        i_ready,
    output t_s1         o_data
);

    logic               r_valid;
    t_s1                r_data;
    t_s1                n_data;
    logic               w_ready;
    logic signed [40:0] w_prod [0:2];
    logic [19:0]        w_fk;
    logic [16:0]        w_ramp_sum;

    assign w_ready = !r_valid || i_ready;

    // velocity times frame time per axis, frame time times gravity, ramp advance, expiry check
    always_comb begin
        n_data.kind   = i_data.kind;
        n_data.ramp   = i_data.ramp;
        n_data.color  = i_data.color;
        n_data.expiry = i_data.expiry;
        n_data.pos    = i_data.pos;
        n_data.vel    = i_data.vel;
        n_data.expired = $signed({i_data.expiry[31], i_data.expiry})
                       < $signed({2'b00, i_current_time});
        for (int i = 0; i < 3; i++) begin
            w_prod[i] = $signed(i_data.vel[i]) * $signed({1'b0, i_frame_time});
            n_data.prod[i] = w_prod[i][39:0];
        end
        n_data.fg = {12'd0, i_frame_time} * {16'd0, i_gravity};
        case (i_data.kind)
            KIND_FIRE:     w_fk = {4'd0, i_frame_time} * 20'd5;
            KIND_EXPLODE:  w_fk = {4'd0, i_frame_time} * 20'd10;
            KIND_EXPLODE2: w_fk = {4'd0, i_frame_time} * 20'd15;
            default:       w_fk = '0;
        endcase
        w_ramp_sum = {1'b0, i_data.ramp} + {1'b0, w_fk[19:4]};
        n_data.ramp_new = w_ramp_sum[16] ? 16'hFFFF : w_ramp_sum[15:0];
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (w_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_ready = w_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* rtl/pus_sum_stage.sv */
module pus_sum_stage
    import pus_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_s1  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_s2  o_data
);

    logic        r_valid;
    t_s2         r_data;
    t_s2         n_data;
    logic        w_ready;
    logic [23:0] w_dpos;
    logic [25:0] w_sh14;
    logic [23:0] w_sh16;
    logic [27:0] w_delta;
    logic [27:0] w_vsum;
    logic [24:0] w_psum;
    logic [3:0]  w_idx;
    logic [3:0]  w_limit;
    logic [31:0] w_gprod;

    assign w_ready = !r_valid || i_ready;

    // position step, velocity growth or damping, ramp colour lookup
    always_comb begin
        n_data.alive  = 1'b1;
        n_data.ramp   = i_data.ramp;
        n_data.color  = i_data.color;
        n_data.expiry = i_data.expiry;
        n_data.vel_z_part = '0;
        n_data.vel_xy = '0;
        w_delta = '0;
        w_vsum  = '0;
        w_psum  = '0;
        w_dpos  = '0;
        w_sh14  = '0;
        w_sh16  = '0;

        for (int i = 0; i < 3; i++) begin
            w_dpos = i_data.prod[i][39:16];
            w_psum = {i_data.pos[i][23], i_data.pos[i]} + {w_dpos[23], w_dpos};
            n_data.pos[i] = sat24($signed({{4{w_psum[24]}}, w_psum}));

            w_sh14 = i_data.prod[i][39:14];
            w_sh16 = i_data.prod[i][39:16];
            case (i_data.kind)
                KIND_EXPLODE, KIND_BLOB: w_delta = {{2{w_sh14[25]}}, w_sh14};
                KIND_EXPLODE2:           w_delta = -{{4{w_sh16[23]}}, w_sh16};
                KIND_BLOB2:              w_delta = (i < 2) ? -{{2{w_sh14[25]}}, w_sh14}
                                                           : 28'd0;
                default:                 w_delta = '0;
            endcase
            w_vsum = {{4{i_data.vel[i][23]}}, i_data.vel[i]} + w_delta;
            if (i < 2) begin
                n_data.vel_xy[i] = sat24($signed({w_vsum[27], w_vsum}));
            end else begin
                n_data.vel_z_part = w_vsum;
            end
        end

        case (i_data.kind)
            KIND_STATIC: n_data.gmode = GMODE_NONE;
            KIND_FIRE:   n_data.gmode = GMODE_ADD;
            default:     n_data.gmode = GMODE_SUB;
        endcase

        // colour ramp for fire and explosions
        w_idx   = i_data.ramp_new[15:12];
        w_limit = (i_data.kind == KIND_FIRE) ? 4'd6 : 4'd8;
        if (i_data.kind == KIND_FIRE || i_data.kind == KIND_EXPLODE
                || i_data.kind == KIND_EXPLODE2) begin
            n_data.ramp = i_data.ramp_new;
            if (w_idx >= w_limit) begin
                n_data.expiry = 32'hFFFFFFFF;
            end else if (i_data.kind == KIND_FIRE) begin
                n_data.color = fire_colour(w_idx[2:0]);
            end else if (i_data.kind == KIND_EXPLODE) begin
                n_data.color = explode_colour(w_idx[2:0]);
            end else begin
                n_data.color = explode2_colour(w_idx[2:0]);
            end
        end

        // dead particle passes through untouched
        if (i_data.expired) begin
            n_data.alive      = 1'b0;
            n_data.ramp       = i_data.ramp;
            n_data.color      = i_data.color;
            n_data.expiry     = i_data.expiry;
            n_data.pos        = i_data.pos;
            n_data.vel_xy[0]  = i_data.vel[0];
            n_data.vel_xy[1]  = i_data.vel[1];
            n_data.vel_z_part = {{4{i_data.vel[2][23]}}, i_data.vel[2]};
            n_data.gmode      = GMODE_NONE;
        end

        // gravity step: (f*g >> 10) / 5 by reciprocal, corrected next stage
        n_data.gy = i_data.fg[27:10];
        w_gprod   = {14'd0, i_data.fg[27:10]} * {18'd0, RECIP5};
        n_data.gq = w_gprod[31:16];
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (w_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_ready = w_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* rtl/pus_grav_stage.sv */
module pus_grav_stage
    import pus_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_s2  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    typedef struct packed {
        logic             alive;
        logic [15:0]      ramp;
        logic [7:0]       color;
        logic [31:0]      expiry;
        logic [2:0][23:0] pos;
        logic [1:0][23:0] vel_xy;
        logic [27:0]      vel_z_part;
        logic [1:0]       gmode;
        logic [15:0]      g;
    } t_s3;

    logic        r_v3;
    logic        r_v4;
    t_s3         r_s3;
    t_s3         n_s3;
    t_out        r_out;
    t_out        n_out;
    logic        w_rdy3;
    logic        w_rdy4;
    logic [18:0] w_five_q;
    logic [18:0] w_rem;
    logic [28:0] w_vz;

    assign w_rdy4 = !r_v4 || i_ready;
    assign w_rdy3 = !r_v3 || w_rdy4;

    // finish the divide by five: quotient estimate is exact or one short
    always_comb begin
        n_s3.alive      = i_data.alive;
        n_s3.ramp       = i_data.ramp;
        n_s3.color      = i_data.color;
        n_s3.expiry     = i_data.expiry;
        n_s3.pos        = i_data.pos;
        n_s3.vel_xy     = i_data.vel_xy;
        n_s3.vel_z_part = i_data.vel_z_part;
        n_s3.gmode      = i_data.gmode;
        w_five_q = {1'b0, i_data.gq, 2'b00} + {3'd0, i_data.gq};
        w_rem    = {1'b0, i_data.gy} - w_five_q;
        n_s3.g   = (w_rem >= 19'd5) ? i_data.gq + 16'd1 : i_data.gq;
    end

    // apply gravity to vertical velocity and saturate
    always_comb begin
        case (r_s3.gmode)
            GMODE_ADD: w_vz = {r_s3.vel_z_part[27], r_s3.vel_z_part} + {13'd0, r_s3.g};
            GMODE_SUB: w_vz = {r_s3.vel_z_part[27], r_s3.vel_z_part} - {13'd0, r_s3.g};
            default:   w_vz = {r_s3.vel_z_part[27], r_s3.vel_z_part};
        endcase
        n_out.alive  = r_s3.alive;
        n_out.ramp   = r_s3.ramp;
        n_out.color  = r_s3.color;
        n_out.expiry = r_s3.expiry;
        n_out.pos    = r_s3.pos;
        n_out.vel[0] = r_s3.vel_xy[0];
        n_out.vel[1] = r_s3.vel_xy[1];
        n_out.vel[2] = sat24($signed(w_vz));
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy3) begin
                r_v3 <= i_valid;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (w_rdy3 && i_valid) begin
            r_s3 <= n_s3;
        end
        if (w_rdy4 && r_v3) begin
            r_out <= n_out;
        end
    end

    assign o_ready = w_rdy3;
    assign o_valid = r_v4;
    assign o_data  = r_out;

    // a waiting result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && !i_ready |=> r_v4 && $stable(r_out))
        else $error("result changed while stalled");

    // gravity step never beyond its largest possible value
    a_g_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> r_s3.g <= G_MAX)
        else $error("gravity step out of range");

    // an item in stage three moves on when stage four can take it
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && w_rdy4 |=> r_v4)
        else $error("item lost between stages");

endmodule

/* rtl/particle_update_step_core.sv */
// throughput: one particle per cycle while the output stream is not stalled; four
// register stages (multiply, sum, gravity divide correction, gravity apply) each
// with its own valid bit
// reset: synchronous active low; clears the stage valids and sets the
// registers to current time 0, frame time 0, gravity 800
module particle_update_step_core
    import pus_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration write port
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [30:0]  i_cfg_wdata,
    // input stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // ramp_in, color_in, expiry_in, pos_x_in, pos_y_in, pos_z_in,
    // vel_x_in, vel_y_in, vel_z_in
    input  logic [199:0] i_s_tdata,
    // particle_kind
    input  logic [2:0]   i_s_tuser,
    // output stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // ramp_out, color_out, expiry_out, pos_x_out, pos_y_out, pos_z_out,
    // vel_x_out, vel_y_out, vel_z_out
    output logic [199:0] o_m_tdata,
    // alive
    output logic [0:0]   o_m_tuser
);

    logic [30:0] r_current_time;
    logic [15:0] r_frame_time;
    logic [11:0] r_gravity;

    t_in  w_in;
    t_s1  w_s1;
    t_s2  w_s2;
    t_out w_out;
    logic w_s1_valid;
    logic w_s1_ready;
    logic w_s2_valid;
    logic w_s2_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_current_time <= '0;
            r_frame_time   <= '0;
            r_gravity      <= GRAVITY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CURRENT_TIME: r_current_time <= i_cfg_wdata;
                CFG_FRAME_TIME:   r_frame_time   <= i_cfg_wdata[15:0];
                CFG_GRAVITY:      r_gravity      <= i_cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    // unpack input beat
    assign w_in.kind   = i_s_tuser;
    assign w_in.ramp   = i_s_tdata[15:0];
    assign w_in.color  = i_s_tdata[23:16];
    assign w_in.expiry = i_s_tdata[55:24];
    assign w_in.pos[0] = i_s_tdata[79:56];
    assign w_in.pos[1] = i_s_tdata[103:80];
    assign w_in.pos[2] = i_s_tdata[127:104];
    assign w_in.vel[0] = i_s_tdata[151:128];
    assign w_in.vel[1] = i_s_tdata[175:152];
    assign w_in.vel[2] = i_s_tdata[199:176];

    pus_mul_stage u_mul (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_tvalid),
        .o_ready        (o_s_tready),
        .i_data         (w_in),
        .i_current_time (r_current_time),
        .i_frame_time   (r_frame_time),
        .i_gravity      (r_gravity),
        .o_valid        (w_s1_valid),
        .i_ready        (w_s1_ready),
        .o_data         (w_s1)
    );

    pus_sum_stage u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s1_valid),
        .o_ready (w_s1_ready),
        .i_data  (w_s1),
        .o_valid (w_s2_valid),
        .i_ready (w_s2_ready),
        .o_data  (w_s2)
    );

    pus_grav_stage u_grav (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s2_valid),
        .o_ready (w_s2_ready),
        .i_data  (w_s2),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (w_out)
    );

    // pack result beat
    assign o_m_tuser = w_out.alive;
    assign o_m_tdata = {w_out.vel[2], w_out.vel[1], w_out.vel[0],
                        w_out.pos[2], w_out.pos[1], w_out.pos[0],
                        w_out.expiry, w_out.color, w_out.ramp};

endmodule
